[rtl/ssu_pkg.sv]
// ----------------------------------------------------------------------------
// ssu_pkg: shared types for the sorted set union block
// Payload structs for both channels, the cell entry and cell control.
// ----------------------------------------------------------------------------
package ssu_pkg;

   localparam int VALUE_W = 32;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      has_value;
      logic                      end_of_set;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] union_value;
      logic                      last;
      logic                      empty_res;
      logic                      overflow;
   } rsp_type;

   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage

[rtl/ssu_cell.sv]
// ----------------------------------------------------------------------------
// ssu_cell: one storage cell of the sorted insertion chain
// Holds one entry, compares it against the broadcast value, and takes its
// left neighbor, the new value or its right neighbor as the chain dictates.
// ----------------------------------------------------------------------------
module ssu_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  ssu_pkg::cell_ctrl_type       ctrl,
   input  logic signed [31:0]           ins_value,
   input  logic                         prev_lt,
   input  ssu_pkg::entry_type           prev_entry,
   input  ssu_pkg::entry_type           next_entry,
   output ssu_pkg::entry_type           entry,
   output logic                         lt,
   output logic                         eq
);
   import ssu_pkg::*;

   logic                      valid_ff, valid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;

   // The new value sorts before this entry (an empty cell counts as larger).
   assign lt = !valid_ff || (ins_value < value_ff);
   assign eq = valid_ff && (ins_value == value_ff);

   assign entry.valid = valid_ff;
   assign entry.value = value_ff;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      priority if (ctrl.shift) begin
         valid_in = next_entry.valid;
         value_in = next_entry.value;
      end else if (ctrl.insert && prev_lt) begin
         valid_in = prev_entry.valid;
         value_in = prev_entry.value;
      end else if (ctrl.insert && lt) begin
         valid_in = 1'b1;
         value_in = ins_value;
      end else begin
         // Nothing moves: the cell keeps its entry.
         valid_in = valid_ff;
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule

[rtl/sorted_set_union.sv]
// After the end-of-set item of a set is taken, the block enters its emit
// state, and each result of the set is registered on the output once the
// result register is free.
// Value items are taken one per cycle while collecting; a set gives one
// result per stored value (one result for an empty set), and no item is taken while emitting.
// Reset (synchronous, active high) empties the store and clears overflow.
// ----------------------------------------------------------------------------
// sorted_set_union: streaming union of signed integer sets
// A chain of cells keeps the distinct values in ascending order; an
// end-of-set item shifts them out through a registered result stage.
// ----------------------------------------------------------------------------
module sorted_set_union #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssu_pkg::rsp_type rsp_data
);
   import ssu_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Two phases: collecting values, then emitting the stored union.
   localparam logic ST_COLLECT = 1'b0;
   localparam logic ST_EMIT    = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // Chain wiring.
   entry_type     entries   [CAPACITY];
   entry_type     prev_ents [CAPACITY];
   entry_type     next_ents [CAPACITY];
   logic          lt_vec    [CAPACITY];
   logic          prev_lts  [CAPACITY];
   logic [CAPACITY-1:0] eq_vec;
   cell_ctrl_type ctrl;

   logic req_fire;
   logic dup;
   logic full;
   logic fresh;
   logic load_rsp;

   assign req_ready = (state_ff == ST_COLLECT);
   assign req_fire  = req_valid && req_ready;

   // A value already held anywhere in the chain is a duplicate.
   assign dup   = |eq_vec;
   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign fresh = req_fire && req_data.has_value && !dup;

   // In the emit phase the result register refills whenever it is empty or being drained.
   assign load_rsp = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign ctrl.insert = fresh && !full;
   assign ctrl.shift  = load_rsp && (count_ff != '0);

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_chain
         if (gi == 0) begin : g_head
            assign prev_ents[gi] = '0;
            assign prev_lts[gi]  = 1'b0;
         end else begin : g_body
            assign prev_ents[gi] = entries[gi-1];
            assign prev_lts[gi]  = lt_vec[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign next_ents[gi] = '0;
         end else begin : g_link
            assign next_ents[gi] = entries[gi+1];
         end

         ssu_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .ins_value  (req_data.value),
            .prev_lt    (prev_lts[gi]),
            .prev_entry (prev_ents[gi]),
            .next_entry (next_ents[gi]),
            .entry      (entries[gi]),
            .lt         (lt_vec[gi]),
            .eq         (eq_vec[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_COLLECT: begin
            // A new distinct value either enters the chain or, with the
            // store full, is dropped and marks the set as overflowed.
            if (fresh) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            if (req_fire && req_data.end_of_set) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_rsp) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.overflow = ovf_ff;
               if (count_ff == '0) begin
                  // Empty set: a single flagged result.
                  rsp_data_in.union_value = '0;
                  rsp_data_in.last        = 1'b1;
                  rsp_data_in.empty_res   = 1'b1;
               end else begin
                  // The head cell always holds the smallest remaining value.
                  rsp_data_in.union_value = entries[0].value;
                  rsp_data_in.last        = (count_ff == CNT_W'(1));
                  rsp_data_in.empty_res   = 1'b0;
                  count_in                = count_ff - CNT_W'(1);
               end
               if (count_ff <= CNT_W'(1)) begin
                  state_in = ST_COLLECT;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sim/sorted_set_union_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_set_union_checker: result predictor and comparator
// Watches both channels of the sorted set union block, predicts each emitted
// union from the accepted items and compares the results as they arrive.
// ----------------------------------------------------------------------------
module sorted_set_union_checker #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ssu_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ssu_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               expected_left
);
   import ssu_pkg::*;

   // Predicted store: distinct values in ascending signed order.
   logic signed [VALUE_W-1:0] held_values [CAPACITY];
   int                        held_count;
   logic                      dropped;
   rsp_type                   union_q [$];

   function automatic void note_error(input string what, input rsp_type want,
                                      input rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("ERROR: %s: value/last/empty/overflow expected %0d/%b/%b/%b got %0d/%b/%b/%b",
                  what, $signed(want.union_value), want.last, want.empty_res,
                  want.overflow, $signed(got.union_value), got.last, got.empty_res,
                  got.overflow);
      end
   endfunction

   // Insert one value into the predicted store, then queue the whole union
   // when the item closes the set.
   function automatic void absorb_item(input req_type item);
      logic signed [VALUE_W-1:0] v;
      int                        pos;
      rsp_type                   r;
      v = item.value;
      if (item.has_value) begin
         pos = 0;
         while (pos < held_count && held_values[pos] < v) pos++;
         if (!(pos < held_count && held_values[pos] == v)) begin
            if (held_count >= CAPACITY) begin
               dropped = 1'b1;
            end else begin
               for (int i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
               held_values[pos] = v;
               held_count++;
            end
         end
      end
      if (item.end_of_set) begin
         if (held_count == 0) begin
            r.union_value = '0;
            r.last        = 1'b1;
            r.empty_res   = 1'b1;
            r.overflow    = dropped;
            union_q.insert(union_q.size(), r);
         end else begin
            for (int k = 0; k < held_count; k++) begin
               r.union_value = held_values[k];
               r.last        = (k == held_count - 1);
               r.empty_res   = 1'b0;
               r.overflow    = dropped;
               union_q.insert(union_q.size(), r);
            end
         end
         held_count = 0;
         dropped    = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         held_count = 0;
         dropped    = 1'b0;
         union_q.delete();
      end else begin
         if (req_valid && req_ready) absorb_item(req_data);
         if (rsp_valid && rsp_ready) begin
            if (union_q.size() == 0) begin
               want = '0;
               note_error("unexpected result", want, rsp_data);
            end else begin
               want = union_q.pop_front();
               if (rsp_data.union_value !== want.union_value || rsp_data.last !== want.last ||
                   rsp_data.empty_res !== want.empty_res ||
                   rsp_data.overflow !== want.overflow) begin
                  note_error("result mismatch", want, rsp_data);
               end
            end
         end
      end
      expected_left = union_q.size();
   end

endmodule

[sim/sorted_set_union_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_set_union_tb: testbench for the sorted set union block
// Streams directed and random sets of signed values into the block under
// changing idle patterns on both channels; a checker predicts every union.
// ----------------------------------------------------------------------------
module sorted_set_union_tb;
   import ssu_pkg::*;

   localparam int CAPACITY       = 64;
   localparam int CYCLE_LIMIT    = 300000;
   // Tail after the last predicted result, before the verdict.
   localparam int DRAIN_CYCLES   = 8;
   localparam int ITEMS_PER_PHASE = 8;

   localparam logic signed [VALUE_W-1:0] MIN_VALUE = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] MAX_VALUE = 32'sh7fff_ffff;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Idle chances in percent, per cycle, for the sender and the receiver.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches;
   int expected_left;
   int cycle_count   = 0;
   // Items that carry a value or close a set; bare items do not count.
   int phase_items   = 0;

   sorted_set_union #(.CAPACITY(CAPACITY)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   sorted_set_union_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .mismatches    (mismatches),
      .expected_left (expected_left)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver decides its ready for the next edge at each falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog: a run that hangs, or that never delivers every expected
   // result, ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic req_type make_req(input logic signed [VALUE_W-1:0] v,
                                        input logic has, input logic fin);
      req_type r;
      r.value      = v;
      r.has_value  = has;
      r.end_of_set = fin;
      return r;
   endfunction

   // Presents one item from a falling edge and holds it until it is taken.
   // Returns at the falling edge after the accepting rising edge, so back to
   // back items keep valid high without lowering it in between.
   task automatic drive_item(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      @(negedge clock);
      if (item.has_value || item.end_of_set) phase_items++;
   endtask

   // Mostly small values so that duplicates are common, some fully random
   // values and some values at or near the ends of the signed range, or at minus one or zero.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 55) return $signed($urandom_range(0, 20)) - 10;
      if (kind < 80) return $urandom;
      case ($urandom_range(0, 5))
         0:       return MIN_VALUE;
         1:       return MIN_VALUE + 1;
         2:       return MAX_VALUE;
         3:       return MAX_VALUE - 1;
         4:       return -1;
         default: return 0;
      endcase
   endfunction

   // One well-formed set with random content. Bare items are sprinkled in as
   // noise, and the set is closed either on its last value or by a bare end
   // marker. A size of zero gives an empty set.
   task automatic random_set();
      int   size;
      logic closed;
      logic fin;
      size   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      closed = 1'b0;
      for (int i = 0; i < size; i++) begin
         if ($urandom_range(0, 7) == 0) drive_item(make_req($urandom, 1'b0, 1'b0));
         fin = (i == size - 1) && $urandom_range(0, 1);
         drive_item(make_req(pick_value(), 1'b1, fin));
         closed = fin;
      end
      if (!closed) drive_item(make_req($urandom, 1'b0, 1'b1));
   endtask

   // Fills the store to capacity with distinct random values, repeats two
   // of them once it is full (they are simply dropped), then offers
   // extra_new further distinct values, which overflow the store.
   task automatic full_set(input int extra_new);
      int vals [$];
      bit seen [int];
      int v;
      while (vals.size() < CAPACITY + extra_new) begin
         v = $urandom;
         if (!seen.exists(v)) begin
            seen[v] = 1'b1;
            vals.insert(vals.size(), v);
         end
      end
      for (int i = 0; i < CAPACITY; i++) drive_item(make_req(vals[i], 1'b1, 1'b0));
      repeat (2) drive_item(make_req(vals[$urandom_range(0, CAPACITY - 1)], 1'b1, 1'b0));
      for (int i = CAPACITY; i < vals.size(); i++) drive_item(make_req(vals[i], 1'b1, 1'b0));
      drive_item(make_req($urandom, 1'b0, 1'b1));
   endtask

   initial begin
      send_idle_pct = 8;
      recv_idle_pct = 78;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. An end marker with nothing stored gives the single
      // empty result.
      drive_item(make_req($urandom, 1'b0, 1'b1));
      // Bare items carry nothing and must cause no result.
      drive_item(make_req($urandom, 1'b0, 1'b0));
      drive_item(make_req(~32'sd0, 1'b0, 1'b0));
      // A value together with the end flag is inserted before the union
      // goes out, so this set holds exactly that value.
      drive_item(make_req(MAX_VALUE, 1'b1, 1'b1));
      // Both ends of the signed range, zero and minus one, with repeats
      // that must be dropped, closed by a bare end marker.
      drive_item(make_req(0, 1'b1, 1'b0));
      drive_item(make_req(-1, 1'b1, 1'b0));
      drive_item(make_req(MIN_VALUE, 1'b1, 1'b0));
      drive_item(make_req(MAX_VALUE, 1'b1, 1'b0));
      drive_item(make_req(-1, 1'b1, 1'b0));
      drive_item(make_req(0, 1'b1, 1'b0));
      drive_item(make_req(1, 1'b1, 1'b0));
      drive_item(make_req($urandom, 1'b0, 1'b0));
      drive_item(make_req($urandom, 1'b0, 1'b1));
      // Descending arrival, then a repeat that also closes the set.
      drive_item(make_req(5, 1'b1, 1'b0));
      drive_item(make_req(4, 1'b1, 1'b0));
      drive_item(make_req(3, 1'b1, 1'b0));
      drive_item(make_req(2, 1'b1, 1'b0));
      drive_item(make_req(1, 1'b1, 1'b0));
      drive_item(make_req(3, 1'b1, 1'b1));
      // Another empty set right after a non-empty one, with noise before it.
      drive_item(make_req($urandom, 1'b0, 1'b0));
      drive_item(make_req(MIN_VALUE, 1'b0, 1'b1));

      // Random part in three idle patterns: a slow receiver, then a slow
      // sender, then no idling at all. In the last pattern the store is
      // filled to the brim and then pushed past it.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 8;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 8;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_items = 0;
         if (phase == 2) full_set(3);
         while (phase_items < ITEMS_PER_PHASE + (phase == 2 ? CAPACITY + 6 : 0)) random_set();
      end
      req_valid <= 1'b0;

      // Wait for every predicted result, then a short tail so that any
      // stray extra result still shows up as a failure.
      while (expected_left != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/ssu_pkg.sv
rtl/ssu_cell.sv
rtl/sorted_set_union.sv
sim/sorted_set_union_checker.sv
sim/sorted_set_union_tb.sv
